>>> src/pbrdp_pkg.sv
// Shared types and codes for the base relocation directory parser.
package pbrdp_pkg;

  typedef enum logic {
    FUNC_START = 1'b0,
    FUNC_DATA  = 1'b1
  } func_e;

  typedef enum logic [1:0] {
    KIND_RECORD = 2'd0,
    KIND_OK     = 2'd1,
    KIND_FAIL   = 2'd2
  } kind_e;

  typedef enum logic [2:0] {
    ERR_NONE       = 3'd0,
    ERR_SIZE_SHORT = 3'd1,
    ERR_OUT_BOUNDS = 3'd2,
    ERR_BAD_TYPE   = 3'd3,
    ERR_END_MISM   = 3'd4,
    ERR_ALIGN_OVF  = 3'd5
  } err_e;

  typedef enum logic [0:0] {
    REG_DIR_START_RVA = 1'b0,
    REG_DIR_BYTE_SIZE = 1'b1
  } cfg_reg_e;

  // header halfword position, then block body
  typedef enum logic [2:0] {
    PH_PAGE_LO = 3'd0,
    PH_PAGE_HI = 3'd1,
    PH_SIZE_LO = 3'd2,
    PH_SIZE_HI = 3'd3,
    PH_BODY    = 3'd4
  } phase_e;

  typedef enum logic [1:0] {
    EV_NONE,
    EV_OK,
    EV_FAIL,
    EV_REC
  } event_e;

  localparam logic [3:0] RT_ABSOLUTE = 4'd0;
  localparam logic [3:0] RT_HIGHLOW  = 4'd3;
  localparam logic [3:0] RT_DIR64    = 4'd10;

  localparam logic [31:0] HDR_BYTES = 32'd8;
  localparam logic [31:0] TOP_LIMIT = 32'hFFFF_FFFC;

  typedef struct packed {
    logic        func;
    logic [15:0] half_word;
  } in_t;

  typedef struct packed {
    kind_e       kind;
    logic [3:0]  reloc_kind;
    logic [31:0] target_rva;
    err_e        error_code;
    logic [3:0]  bad_type;
  } out_t;

  typedef struct packed {
    logic [31:0] dir_start_rva;
    logic [31:0] dir_byte_size;
  } cfg_t;

  typedef struct packed {
    logic valid;
    out_t data;
  } step_res_t;

endpackage

>>> src/pe_base_reloc_directory_parser.sv
// Top level of the PE base relocation directory parser.
//
// Input channel (in_valid_i / in_stall_o / in_data_i): one item per
// accepted edge. func = start latches the directory bounds from the
// config registers and opens a scan; func = data carries the next
// little-endian halfword of the relocation directory.
// Output channel (out_valid_o / out_stall_i / out_data_o): at most one
// item per input item - a relocation record, a success verdict or a
// failure with its error code.
// Config port: cfg_we_i writes cfg_wdata_i to register cfg_idx_i
// (0 start RVA, 1 byte size); write only while the parser is idle.
// Path: an accepted item waits in the input register, then one pass of
// step logic writes its result, if any, into the output register.
// Throughput: one item per cycle while the output is not stalled.
// Stall: the output register holds while out_stall_i is high; one more
// item waits in the input register, then in_stall_o rises.
// Reset: no scan open, halfwords ignored until a start item; config
// registers cleared to zero.
module pe_base_reloc_directory_parser
  import pbrdp_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  in_t         in_data_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output out_t        out_data_o,
  input  logic        cfg_we_i,
  input  logic [0:0]  cfg_idx_i,
  input  logic [31:0] cfg_wdata_i
);

  cfg_t      cfg;
  step_res_t res;

  logic in_vld_q;
  in_t  in_q;
  logic out_vld_q;
  out_t out_q;
  logic fire, accept;

  // step fires when the output register is free or draining this cycle
  assign fire       = in_vld_q && (!out_vld_q || !out_stall_i);
  assign in_stall_o = in_vld_q && !fire;
  assign accept     = in_valid_i && !in_stall_o;

  pbrdp_cfg_regs u_cfg (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_wdata_i(cfg_wdata_i),
    .cfg_o      (cfg)
  );

  pbrdp_core u_core (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .fire_i(fire),
    .item_i(in_q),
    .cfg_i (cfg),
    .res_o (res)
  );

  // input register valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else if (accept) begin
      in_vld_q <= 1'b1;
    end else if (fire) begin
      in_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      in_q <= in_data_i;
    end
  end

  // output register valid; an item without a result leaves it empty
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (fire) begin
      out_vld_q <= res.valid;
    end else if (!out_stall_i) begin
      out_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire && res.valid) begin
      out_q <= res.data;
    end
  end

  assign out_valid_o = out_vld_q;
  assign out_data_o  = out_q;

endmodule

>>> src/pbrdp_cfg_regs.sv
// Directory bounds register file.
module pbrdp_cfg_regs
  import pbrdp_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [0:0]  cfg_idx_i,
  input  logic [31:0] cfg_wdata_i,
  output cfg_t        cfg_o
);

  cfg_t cfg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_reg_e'(cfg_idx_i))
        REG_DIR_START_RVA: cfg_q.dir_start_rva <= cfg_wdata_i;
        REG_DIR_BYTE_SIZE: cfg_q.dir_byte_size <= cfg_wdata_i;
        default: cfg_q <= cfg_q;
      endcase
    end
  end

  assign cfg_o = cfg_q;

endmodule

>>> src/pbrdp_core.sv
// Scan state and the single-pass step logic for one directory item.
module pbrdp_core
  import pbrdp_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      fire_i,
  input  in_t       item_i,
  input  cfg_t      cfg_i,
  output step_res_t res_o
);

  logic [31:0] cur_q, cur_d;
  logic [31:0] atop_q, atop_d;     // directory end rounded up to 4
  logic [31:0] tm8_q, tm8_d;       // unaligned end minus header size
  logic        tge8_q, tge8_d;     // unaligned end is at least 8
  logic [31:0] page_q, page_d;
  logic [31:0] bsize_q, bsize_d;
  logic [31:0] alsz_q, alsz_d;     // block size rounded up to 4
  logic [30:0] ent_q, ent_d;
  logic [1:0]  pad_q, pad_d;
  phase_e      phase_q, phase_d;
  logic        over_q, over_d;
  logic        held_q, held_d;

  // shared arithmetic
  logic [31:0] raw_top, raw_p3, start_atop;
  logic        start_more;
  logic [31:0] new_bs, relsz, lim, bs_p3, al_new;
  logic [1:0]  pad_hdr;
  logic [31:0] cur_p8, end_cur;
  logic        hdr_more, body_more;
  logic [3:0]  etype;
  logic [31:0] rec_tgt;

  assign raw_top    = cfg_i.dir_start_rva + cfg_i.dir_byte_size;
  assign raw_p3     = raw_top + 32'd3;
  assign start_atop = {raw_p3[31:2], 2'b00};
  assign start_more = (raw_top >= HDR_BYTES) && (cfg_i.dir_start_rva <= raw_top - HDR_BYTES);

  assign new_bs  = {item_i.half_word, bsize_q[15:0]};
  assign relsz   = new_bs - HDR_BYTES;
  assign lim     = tm8_q - cur_q;
  assign bs_p3   = new_bs + 32'd3;
  assign al_new  = {bs_p3[31:2], 2'b00};
  // low bits of (aligned body halfwords - entry count)
  assign pad_hdr = {al_new[2], 1'b0} - relsz[2:1];

  assign cur_p8    = cur_q + HDR_BYTES;
  assign end_cur   = cur_q + alsz_q;
  assign hdr_more  = tge8_q && (cur_p8 <= tm8_q);
  assign body_more = tge8_q && (end_cur <= tm8_q);

  assign etype   = item_i.half_word[15:12];
  assign rec_tgt = page_q + {20'd0, item_i.half_word[11:0]};

  event_e      ev;
  err_e        ev_err;
  logic [3:0]  ev_bad;
  logic        do_verdict;
  logic [31:0] v_cur, v_top;
  logic [30:0] ent_n;
  logic [1:0]  pad_n;
  logic        is_rec;

  // next state and step event
  always_comb begin
    cur_d      = cur_q;
    atop_d     = atop_q;
    tm8_d      = tm8_q;
    tge8_d     = tge8_q;
    page_d     = page_q;
    bsize_d    = bsize_q;
    alsz_d     = alsz_q;
    ent_d      = ent_q;
    pad_d      = pad_q;
    phase_d    = phase_q;
    over_d     = over_q;
    held_d     = held_q;
    ev         = EV_NONE;
    ev_err     = ERR_NONE;
    ev_bad     = 4'd0;
    do_verdict = 1'b0;
    v_cur      = cur_q;
    v_top      = atop_q;
    ent_n      = ent_q;
    pad_n      = pad_q;
    is_rec     = 1'b0;

    if (fire_i) begin
      if (item_i.func == FUNC_START) begin
        held_d  = 1'b0;
        over_d  = 1'b0;
        phase_d = PH_PAGE_LO;
        ent_d   = '0;
        pad_d   = '0;
        cur_d   = cfg_i.dir_start_rva;
        if (cfg_i.dir_byte_size == 32'd0) begin
          over_d = 1'b1;
          ev     = EV_OK;
        end else begin
          tm8_d  = raw_top - HDR_BYTES;
          tge8_d = (raw_top >= HDR_BYTES);
          if (raw_top > TOP_LIMIT) begin
            over_d = 1'b1;
            ev     = EV_FAIL;
            ev_err = ERR_ALIGN_OVF;
          end else begin
            atop_d = start_atop;
            if (!start_more) begin
              do_verdict = 1'b1;
              v_cur      = cfg_i.dir_start_rva;
              v_top      = start_atop;
            end
          end
        end
      end else if (held_q) begin
        held_d     = 1'b0;
        do_verdict = 1'b1;
      end else if (!over_q) begin
        unique case (phase_q)
          PH_PAGE_LO: begin
            page_d[15:0] = item_i.half_word;
            phase_d      = PH_PAGE_HI;
          end
          PH_PAGE_HI: begin
            page_d[31:16] = item_i.half_word;
            phase_d       = PH_SIZE_LO;
          end
          PH_SIZE_LO: begin
            bsize_d[15:0] = item_i.half_word;
            phase_d       = PH_SIZE_HI;
          end
          PH_SIZE_HI: begin
            bsize_d = new_bs;
            if (new_bs < HDR_BYTES) begin
              over_d = 1'b1;
              ev     = EV_FAIL;
              ev_err = ERR_SIZE_SHORT;
            end else if (relsz > lim) begin
              over_d = 1'b1;
              ev     = EV_FAIL;
              ev_err = ERR_OUT_BOUNDS;
            end else begin
              ent_d   = relsz[31:1];
              pad_d   = pad_hdr;
              alsz_d  = al_new;
              phase_d = PH_BODY;
              // bare 8-byte header: block closes at once
              if (relsz[31:1] == 31'd0 && pad_hdr == 2'd0) begin
                cur_d   = cur_p8;
                phase_d = PH_PAGE_LO;
                if (!hdr_more) begin
                  do_verdict = 1'b1;
                  v_cur      = cur_p8;
                end
              end
            end
          end
          PH_BODY: begin
            if (ent_q != 31'd0) begin
              ent_n = ent_q - 31'd1;
              if (etype == RT_HIGHLOW || etype == RT_DIR64) begin
                is_rec = 1'b1;
                ev     = EV_REC;
              end else if (etype != RT_ABSOLUTE) begin
                over_d = 1'b1;
                ev     = EV_FAIL;
                ev_err = ERR_BAD_TYPE;
                ev_bad = etype;
              end
            end else if (pad_q != 2'd0) begin
              pad_n = pad_q - 2'd1;
            end
            ent_d = ent_n;
            pad_d = pad_n;
            if (ev != EV_FAIL && ent_n == 31'd0 && pad_n == 2'd0) begin
              cur_d   = end_cur;
              phase_d = PH_PAGE_LO;
              if (!body_more) begin
                if (is_rec) begin
                  held_d = 1'b1;   // verdict goes out on the next data item
                end else begin
                  do_verdict = 1'b1;
                  v_cur      = end_cur;
                end
              end
            end
          end
          default: phase_d = phase_q;
        endcase
      end

      if (do_verdict) begin
        over_d = 1'b1;
        if (v_cur == v_top) begin
          ev = EV_OK;
        end else begin
          ev     = EV_FAIL;
          ev_err = ERR_END_MISM;
        end
      end
    end
  end

  // result formatting
  always_comb begin
    res_o      = '0;
    res_o.data = '{kind: KIND_RECORD, reloc_kind: 4'd0, target_rva: 32'd0,
                   error_code: ERR_NONE, bad_type: 4'd0};
    unique case (ev)
      EV_NONE: res_o.valid = 1'b0;
      EV_OK: begin
        res_o.valid     = 1'b1;
        res_o.data.kind = KIND_OK;
      end
      EV_FAIL: begin
        res_o.valid           = 1'b1;
        res_o.data.kind       = KIND_FAIL;
        res_o.data.error_code = ev_err;
        res_o.data.bad_type   = ev_bad;
      end
      EV_REC: begin
        res_o.valid           = 1'b1;
        res_o.data.kind       = KIND_RECORD;
        res_o.data.reloc_kind = etype;
        res_o.data.target_rva = rec_tgt;
      end
      default: res_o.valid = 1'b0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cur_q   <= '0;
      atop_q  <= '0;
      tm8_q   <= '0;
      tge8_q  <= 1'b0;
      page_q  <= '0;
      bsize_q <= '0;
      alsz_q  <= '0;
      ent_q   <= '0;
      pad_q   <= '0;
      phase_q <= PH_PAGE_LO;
      over_q  <= 1'b1;
      held_q  <= 1'b0;
    end else begin
      cur_q   <= cur_d;
      atop_q  <= atop_d;
      tm8_q   <= tm8_d;
      tge8_q  <= tge8_d;
      page_q  <= page_d;
      bsize_q <= bsize_d;
      alsz_q  <= alsz_d;
      ent_q   <= ent_d;
      pad_q   <= pad_d;
      phase_q <= phase_d;
      over_q  <= over_d;
      held_q  <= held_d;
    end
  end

endmodule

>>> src/pbrdp_checker.sv
// Port-level checks for the relocation directory parser, bound to the top level.
module pbrdp_checker
  import pbrdp_pkg::*;
(
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_valid_i,
  input logic        in_stall_o,
  input logic        out_valid_o,
  input logic        out_stall_i,
  input out_t        out_data_o
);

  // input only backs up behind a stalled result
  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> (out_valid_o && out_stall_i))
    else $error("input stalled without a stalled result");

  a_rec_fields: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_data_o.kind == KIND_RECORD) |->
      ((out_data_o.reloc_kind == RT_HIGHLOW || out_data_o.reloc_kind == RT_DIR64)
       && out_data_o.error_code == ERR_NONE && out_data_o.bad_type == 4'd0))
    else $error("malformed relocation record");

  a_fail_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_data_o.kind == KIND_FAIL) |->
      (out_data_o.error_code != ERR_NONE && out_data_o.target_rva == 32'd0 &&
       (out_data_o.bad_type == 4'd0 || out_data_o.error_code == ERR_BAD_TYPE)))
    else $error("failure item with inconsistent code");

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_stall_i) |=> (out_valid_o && $stable(out_data_o)))
    else $error("stalled result changed");

endmodule

bind pe_base_reloc_directory_parser pbrdp_checker u_pbrdp_checker (.*);

>>> verif/tb.sv
// Self-checking testbench for the PE base relocation directory parser.
module tb;
  import pbrdp_pkg::*;

  // Tracks the scan exactly as the parser should and queues the result items
  // that each accepted input item must produce.
  class reloc_scan_tracker;
    logic [31:0] start_rva, byte_size;
    logic [31:0] cur_rva, aligned_top, raw_top, page_addr, blk_size;
    logic [30:0] entries_left;
    logic [1:0]  pad_left;
    phase_e      phase;
    bit          scan_over, verdict_held;
    out_t        last_result;
    out_t        due_results[$];
    int          errors;

    function new();
      start_rva = '0; byte_size = '0;
      cur_rva = '0; aligned_top = '0; raw_top = '0; page_addr = '0; blk_size = '0;
      entries_left = '0; pad_left = '0; phase = PH_PAGE_LO;
      scan_over = 1'b1; verdict_held = 1'b0; errors = 0;
    endfunction

    static function logic [31:0] round_up4(logic [31:0] v);
      return (v + 32'd3) & ~32'd3;
    endfunction

    function void set_reg(cfg_reg_e idx, logic [31:0] v);
      case (idx)
        REG_DIR_START_RVA: start_rva = v;
        default:           byte_size = v;
      endcase
    endfunction

    function bit put_result(kind_e k, logic [3:0] rk, logic [31:0] tgt, err_e e,
                            logic [3:0] bad);
      last_result.kind       = k;
      last_result.reloc_kind = rk;
      last_result.target_rva = tgt;
      last_result.error_code = e;
      last_result.bad_type   = bad;
      return 1'b1;
    endfunction

    function bit fail_scan(err_e e, logic [3:0] bad);
      scan_over = 1'b1;
      return put_result(KIND_FAIL, 4'd0, 32'd0, e, bad);
    endfunction

    function bit more_blocks();
      return raw_top >= HDR_BYTES && cur_rva <= raw_top - HDR_BYTES;
    endfunction

    function bit verdict();
      if (cur_rva == aligned_top) begin
        scan_over = 1'b1;
        return put_result(KIND_OK, 4'd0, 32'd0, ERR_NONE, 4'd0);
      end
      return fail_scan(ERR_END_MISM, 4'd0);
    endfunction

    // When the last block closes on a record, the verdict is held back for one data item.
    function bit end_block(bit rec);
      cur_rva = cur_rva + round_up4(blk_size);
      phase = PH_PAGE_LO;
      if (more_blocks()) return rec;
      if (rec) begin
        verdict_held = 1'b1;
        return 1'b1;
      end
      return verdict();
    endfunction

    function bit parse_item(in_t it);
      logic [15:0] hw;
      logic [3:0]  ty;
      logic [31:0] relsz, body;
      bit          rec;
      hw = it.half_word;
      if (it.func == FUNC_START) begin
        verdict_held = 1'b0;
        scan_over = 1'b0;
        phase = PH_PAGE_LO;
        entries_left = '0;
        pad_left = '0;
        cur_rva = start_rva;
        if (byte_size == 32'd0) begin
          scan_over = 1'b1;
          return put_result(KIND_OK, 4'd0, 32'd0, ERR_NONE, 4'd0);
        end
        raw_top = start_rva + byte_size;
        if (raw_top > TOP_LIMIT) return fail_scan(ERR_ALIGN_OVF, 4'd0);
        aligned_top = round_up4(raw_top);
        if (!more_blocks()) return verdict();
        return 1'b0;
      end
      if (verdict_held) begin
        verdict_held = 1'b0;
        return verdict();
      end
      if (scan_over) return 1'b0;
      if (phase != PH_BODY) begin
        case (phase)
          PH_PAGE_LO: page_addr[15:0]  = hw;
          PH_PAGE_HI: page_addr[31:16] = hw;
          PH_SIZE_LO: blk_size[15:0]   = hw;
          default:    blk_size[31:16]  = hw;
        endcase
        if (phase != PH_SIZE_HI) begin
          phase = phase_e'(phase + 3'd1);
          return 1'b0;
        end
        if (blk_size < HDR_BYTES) return fail_scan(ERR_SIZE_SHORT, 4'd0);
        relsz = blk_size - HDR_BYTES;
        if (relsz > (raw_top - HDR_BYTES) - cur_rva) return fail_scan(ERR_OUT_BOUNDS, 4'd0);
        entries_left = relsz[31:1];
        body = (round_up4(blk_size) - HDR_BYTES) >> 1;
        pad_left = 2'(body - {1'b0, entries_left});
        phase = PH_BODY;
        if (entries_left == '0 && pad_left == '0) return end_block(1'b0);
        return 1'b0;
      end
      rec = 1'b0;
      if (entries_left != '0) begin
        ty = hw[15:12];
        entries_left--;
        if (ty == RT_HIGHLOW || ty == RT_DIR64) begin
          rec = put_result(KIND_RECORD, ty, page_addr + {20'd0, hw[11:0]}, ERR_NONE, 4'd0);
        end else if (ty != RT_ABSOLUTE) begin
          return fail_scan(ERR_BAD_TYPE, ty);
        end
      end else if (pad_left != '0) begin
        pad_left--;
      end
      if (entries_left == '0 && pad_left == '0) return end_block(rec);
      return rec;
    endfunction

    function void note_item(in_t it);
      if (parse_item(it)) due_results.push_back(last_result);
    endfunction

    function void compare_field(string name, logic [31:0] want, logic [31:0] got);
      if (want !== got) begin
        $error("%s: expected %0h, got %0h", name, want, got);
        errors++;
      end
    endfunction

    function void check_result(out_t got);
      out_t want;
      if (due_results.size() == 0) begin
        $error("unexpected result item: kind %0h target %0h", got.kind, got.target_rva);
        errors++;
        return;
      end
      want = due_results.pop_front();
      compare_field("kind", want.kind, got.kind);
      compare_field("reloc_kind", want.reloc_kind, got.reloc_kind);
      compare_field("target_rva", want.target_rva, got.target_rva);
      compare_field("error_code", want.error_code, got.error_code);
      compare_field("bad_type", want.bad_type, got.bad_type);
    endfunction
  endclass

  logic        clk_i = 1'b0;
  logic        rst_ni;
  logic        in_valid_i;
  logic        in_stall_o;
  in_t         in_data_i;
  logic        out_valid_o;
  logic        out_stall_i;
  out_t        out_data_o;
  logic        cfg_we_i;
  logic [0:0]  cfg_idx_i;
  logic [31:0] cfg_wdata_i;

  int in_idle_pct   = 21;
  int out_stall_pct = 45;
  int items_sent    = 0;

  reloc_scan_tracker sb = new();

  pe_base_reloc_directory_parser uut (.*);

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  // Sink side: random back-pressure, changed on the falling edge.
  always @(negedge clk_i) begin
    out_stall_i <= ($urandom_range(99) < out_stall_pct);
  end

  // Both channels are sampled at the rising edge, before the parser's own
  // registers update, so the handshake values seen are the settled ones.
  always @(posedge clk_i) begin
    if (rst_ni && in_valid_i && !in_stall_o) sb.note_item(in_data_i);
    if (rst_ni && out_valid_o && !out_stall_i) sb.check_result(out_data_o);
  end

  // One input item; the sender may first sit idle for a random time.
  task automatic send_item(func_e f, logic [15:0] w);
    @(negedge clk_i);
    while ($urandom_range(99) < in_idle_pct) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i  <= {f, w};
    do @(posedge clk_i); while (in_stall_o);
    items_sent++;
  endtask

  // Drop valid, let every expected item come out, then allow for the
  // pipeline to finish anything that produces no result.
  task automatic settle();
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (sb.due_results.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic write_reg(cfg_reg_e idx, logic [31:0] v);
    @(negedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= v;
    sb.set_reg(idx, v);
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  task automatic push_hdr(ref logic [15:0] q[$], input logic [31:0] page,
                          input logic [31:0] bsz);
    q.push_back(page[15:0]);
    q.push_back(page[31:16]);
    q.push_back(bsz[15:0]);
    q.push_back(bsz[31:16]);
  endtask

  // Header plus body halfwords, padding included; types are mostly valid,
  // with the odd unknown one.
  task automatic add_block(ref logic [15:0] q[$], input logic [31:0] page,
                           input logic [31:0] bsz);
    int          r;
    logic [3:0]  ty;
    push_hdr(q, page, bsz);
    for (int i = 0; i < int'(reloc_scan_tracker::round_up4(bsz) >> 1) - 4; i++) begin
      r = $urandom_range(149);
      ty = (r == 0) ? 4'($urandom) : (r < 55) ? RT_HIGHLOW : (r < 110) ? RT_DIR64 : RT_ABSOLUTE;
      q.push_back({ty, 12'($urandom)});
    end
  endtask

  // Program the bounds, start the scan, stream the directory. A restart
  // point, if given, inserts a second start part-way and replays from the top.
  task automatic run_scan(input logic [31:0] start, input logic [31:0] size,
                          input logic [15:0] words[$], input int restart_at);
    write_reg(REG_DIR_START_RVA, start);
    write_reg(REG_DIR_BYTE_SIZE, size);
    send_item(FUNC_START, 16'($urandom));
    for (int i = 0; i < restart_at; i++) send_item(FUNC_DATA, words[i]);
    if (restart_at >= 0) send_item(FUNC_START, 16'($urandom));
    foreach (words[i]) send_item(FUNC_DATA, words[i]);
    settle();
  endtask

  // Mostly well-formed directories with random content and bounds that fit
  // or nearly fit; the rest is raw noise under arbitrary bounds.
  task automatic random_scan();
    logic [15:0] q[$];
    logic [31:0] sum, start, size, bsz, page;
    int          r, restart_at;
    sum = '0;
    if ($urandom_range(99) < 12) begin
      repeat ($urandom_range(6, 30)) q.push_back(16'($urandom));
      start = $urandom_range(1) ? $urandom : 32'd0;
      size  = $urandom_range(1) ? $urandom_range(0, 64) : $urandom;
    end else begin
      repeat ($urandom_range(1, 5)) begin
        r = $urandom_range(99);
        page = (r < 5) ? 32'hFFFF_F000 : (r < 15) ? $urandom : ($urandom & 32'hFFFF_F000);
        bsz = 32'd8 + 2 * $urandom_range(0, 10);
        r = $urandom_range(99);
        if (r < 2) bsz = $urandom_range(0, 7);
        else if (r < 22) bsz++;
        add_block(q, page, bsz);
        sum += reloc_scan_tracker::round_up4(bsz);
      end
      r = $urandom_range(99);
      if (r < 75)      start = $urandom & 32'h7FFF_FFFC;
      else if (r < 87) start = TOP_LIMIT - sum - 4 * $urandom_range(0, 2);
      else if (r < 94) start = $urandom & 32'h7FFF_FFFF;
      else             start = $urandom;
      r = $urandom_range(99);
      if (r < 75)      size = sum;
      else if (r < 92) size = sum + $urandom_range(0, 12) - 6;
      else             size = sum + 8 + $urandom_range(0, 31);
      // trailing words release a held verdict, then are ignored
      repeat ($urandom_range(1, 3)) q.push_back(16'($urandom));
      if ($urandom_range(99) < 5) repeat ($urandom_range(1, q.size() - 1)) void'(q.pop_back());
    end
    restart_at = ($urandom_range(99) < 6) ? $urandom_range(1, q.size() - 1) : -1;
    run_scan(start, size, q, restart_at);
  endtask

  initial begin
    logic [15:0] q[$];
    logic [15:0] none[$];
    rst_ni      = 1'b0;
    in_valid_i  = 1'b0;
    in_data_i   = '0;
    out_stall_i = 1'b0;
    cfg_we_i    = 1'b0;
    cfg_idx_i   = REG_DIR_START_RVA;
    cfg_wdata_i = '0;
    repeat (2) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // halfword before any start: ignored
    send_item(FUNC_DATA, 16'hFFFF);
    settle();
    // empty directory succeeds at once; the following halfword is ignored
    none.push_back(16'h0000);
    run_scan(32'd0, 32'd0, none, -1);
    none.delete();
    // end beyond the last aligned address
    run_scan(32'hFFFF_FFFF, 32'hFFFF_FFFF, none, -1);
    // end wraps round below the header size: straight to the end check
    run_scan(32'hFFFF_FFF8, 32'd12, none, -1);
    // too small for a header, no wrap
    run_scan(32'd0, 32'd4, none, -1);

    // Three blocks: odd size with padding, header only, then one closing on a
    // record so the verdict waits for the next data item. Targets wrap.
    push_hdr(q, 32'hFFFF_F000, 32'd13);
    q.push_back({RT_HIGHLOW, 12'hFFF});
    q.push_back({RT_DIR64, 12'h123});
    q.push_back(16'hFFFF);
    q.push_back(16'h0000);
    push_hdr(q, 32'h0000_0000, 32'd8);
    push_hdr(q, 32'hFFFF_FFFF, 32'd12);
    q.push_back({RT_ABSOLUTE, 12'hABC});
    q.push_back({RT_DIR64, 12'h001});
    q.push_back(16'h5A5A);
    q.push_back(16'hA5A5);
    run_scan(32'h0000_2000, 32'd36, q, -1);

    // block size below the header
    q.delete();
    push_hdr(q, 32'h0000_1000, 32'd5);
    run_scan(32'd0, 32'd64, q, -1);
    // block runs past the directory end
    q.delete();
    push_hdr(q, 32'h0000_1000, 32'd24);
    run_scan(32'd0, 32'd16, q, -1);
    // unknown relocation type
    q.delete();
    push_hdr(q, 32'h0000_0000, 32'd12);
    q.push_back({4'd7, 12'h000});
    run_scan(32'd0, 32'd12, q, -1);

    while (items_sent < 630) random_scan();
    in_idle_pct   = 45;
    out_stall_pct = 21;
    while (items_sent < 1260) random_scan();
    in_idle_pct   = 0;
    out_stall_pct = 0;
    while (items_sent < 1900) random_scan();

    if (sb.errors == 0 && sb.due_results.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

  // Watchdog: far beyond the slowest legal run.
  initial begin
    #2_000_000;
    $display("TEST FAILED");
    $finish;
  end

endmodule

>>> filelist.f
src/pbrdp_pkg.sv
src/pbrdp_cfg_regs.sv
src/pbrdp_core.sv
src/pe_base_reloc_directory_parser.sv
src/pbrdp_checker.sv
verif/tb.sv
